// ===== rtl/qwt_pkg.sv =====
// Package for the quoted word tokenizer.
// Holds the scan mode encoding, character codes and the step structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qwt_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam int LEN_W = 9;
	localparam int IDX_W = 8;

	typedef enum logic [5:0] {
		MODE_START  = 6'b000001,
		MODE_WORD   = 6'b000010,
		MODE_ESC    = 6'b000100,
		MODE_SQ     = 6'b001000,
		MODE_DQ     = 6'b010000,
		MODE_DQ_ESC = 6'b100000
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [LEN_W-1:0]  char_count;
		logic [IDX_W-1:0]  word_count;
	} scan_state_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic              byte_kept;
		logic              word_end;
		logic [IDX_W-1:0]  word_index;
		logic [LEN_W-1:0]  word_length;
		logic              line_done;
	} scan_result_t;

endpackage

`default_nettype wire

// ===== rtl/qwt_scan.sv =====
// Next-state and result logic for one byte of the tokenizer.
// Purely combinational; uses qwt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qwt_scan import qwt_pkg::*; #(
	parameter int LEN_CAP = 256,
	parameter int IDX_CAP = 255
) (
	input  wire logic [7:0]   in_byte,
	input  wire logic         is_last,
	input  wire scan_state_t  cur,
	output scan_state_t       nxt,
	output scan_result_t      res
);

	localparam logic [LEN_W-1:0] LenCapV = LEN_W'(LEN_CAP);
	localparam logic [IDX_W-1:0] IdxCapV = IDX_W'(IDX_CAP);

	logic             is_ws;
	logic             take;
	logic             fits;
	logic             ws_end;
	mode_t            mode_n;
	logic [LEN_W-1:0] cnt_n;

	assign is_ws = (in_byte == CH_SPACE) || (in_byte == CH_CR) ||
		(in_byte == CH_LF) || (in_byte == CH_TAB);
	assign fits  = cur.char_count < LenCapV;

	always_comb begin
		take   = 1'b0;
		ws_end = 1'b0;
		mode_n = cur.mode;
		unique case (cur.mode)
			MODE_WORD: begin
				if (in_byte == CH_BSLASH) mode_n = MODE_ESC;
				else if (is_ws) ws_end = 1'b1;
				else if (in_byte == CH_DQUOTE) mode_n = MODE_DQ;
				else if (in_byte == CH_SQUOTE) mode_n = MODE_SQ;
				else take = 1'b1;
			end
			MODE_ESC: begin
				take   = 1'b1;
				mode_n = MODE_WORD;
			end
			MODE_SQ: begin
				if (in_byte == CH_SQUOTE) mode_n = MODE_WORD;
				else take = 1'b1;
			end
			MODE_DQ: begin
				if (in_byte == CH_BSLASH) mode_n = MODE_DQ_ESC;
				else if (in_byte == CH_DQUOTE) mode_n = MODE_WORD;
				else take = 1'b1;
			end
			MODE_DQ_ESC: begin
				take   = 1'b1;
				mode_n = MODE_DQ;
			end
			default: begin
				if (in_byte == CH_BSLASH) mode_n = MODE_ESC;
				else if (is_ws) mode_n = MODE_START;
				else if (in_byte == CH_DQUOTE) mode_n = MODE_DQ;
				else if (in_byte == CH_SQUOTE) mode_n = MODE_SQ;
				else begin
					take   = 1'b1;
					mode_n = MODE_WORD;
				end
			end
		endcase
	end

	assign cnt_n = cur.char_count + LEN_W'(take && fits);

	always_comb begin
		res.out_byte    = (take && fits) ? in_byte : 8'h00;
		res.byte_kept   = take && fits;
		res.word_end    = ws_end || (is_last && (cnt_n != '0));
		res.word_index  = cur.word_count;
		res.word_length = cnt_n;
		res.line_done   = is_last;

		nxt.mode       = mode_n;
		nxt.char_count = cnt_n;
		nxt.word_count = cur.word_count;
		if (ws_end) begin
			nxt.mode       = MODE_START;
			nxt.char_count = '0;
			if (cur.word_count < IdxCapV) nxt.word_count = cur.word_count + IDX_W'(1);
		end
		if (is_last) begin
			nxt.mode       = MODE_START;
			nxt.char_count = '0;
			nxt.word_count = '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/quoted_word_tokenizer_top.sv =====
// Quoted word tokenizer: splits a command line into shell-style words.
// Holds the input register, scan state and result register; uses qwt_pkg
// and qwt_scan.
//
// Usage: feed the command line one byte per beat on the input channel
// (in_valid/in_stall, in_byte, is_last with is_last on the final byte).
// Every input beat yields exactly one result beat on the output channel
// (out_valid/out_stall) giving the kept byte, word end, word index and
// word length, and line_done echoing is_last.
// Path: an accepted byte is held in the input register, and its result
// is then held in the result register until it is taken.
// Throughput: one byte per cycle while the output is not stalled; the
// scan state is updated as the byte moves from the input register to
// the result register.
// Stall: while the result is stalled it holds; the input register absorbs
// one more byte, then in_stall rises until the result is taken.
// Reset: arst_n clears both valid flags and the scan state (start of word,
// zero length, word index zero). After a last byte the scan state returns
// to the same values.
`timescale 1ns / 1ps
`default_nettype none

module quoted_word_tokenizer_top import qwt_pkg::*; #(
	parameter int MAX_WORD_LEN = 256,
	parameter int MAX_WORDS    = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       in_byte,
	input  wire logic             is_last,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [7:0]            out_byte,
	output logic                  byte_kept,
	output logic                  word_end,
	output logic [IDX_W-1:0]      word_index,
	output logic [LEN_W-1:0]      word_length,
	output logic                  line_done
);

	localparam int LenCap = (MAX_WORD_LEN < 511) ? MAX_WORD_LEN : 511;
	localparam int IdxCap = ((MAX_WORDS - 1) < 255) ? (MAX_WORDS - 1) : 255;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         valid_s2;
	scan_result_t res_s2;
	scan_state_t  state_q;
	scan_state_t  state_n;
	scan_result_t res_n;
	logic         adv;
	logic         take_in;
	logic         step;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign take_in  = in_valid && !in_stall;
	assign step     = valid_s1 && adv;

	qwt_scan #(
		.LEN_CAP(LenCap),
		.IDX_CAP(IdxCap)
	) u_scan (
		.in_byte(byte_s1),
		.is_last(last_s1),
		.cur(state_q),
		.nxt(state_n),
		.res(res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{mode: MODE_START, char_count: '0, word_count: '0};
		end else begin
			if (take_in) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) valid_s2 <= valid_s1;
			if (step) state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= in_byte;
			last_s1 <= is_last;
		end
		if (step) res_s2 <= res_n;
	end

	assign out_valid   = valid_s2;
	assign out_byte    = res_s2.out_byte;
	assign byte_kept   = res_s2.byte_kept;
	assign word_end    = res_s2.word_end;
	assign word_index  = res_s2.word_index;
	assign word_length = res_s2.word_length;
	assign line_done   = res_s2.line_done;

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.char_count <= LEN_W'(LenCap))
		else $error("char count above cap");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> (state_q.mode == MODE_START &&
		state_q.char_count == '0 && state_q.word_count == '0))
		else $error("scan state not reset after last byte");

	a_kept_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_kept) |-> (word_length != '0))
		else $error("kept byte with zero word length");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall))
		else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
